/* rtl/msp_pkg.sv */
package msp_pkg;

	// field widths
	localparam int COORD_W    = 8;
	localparam int LEVEL_W    = 8;
	localparam int STYLE_W    = 3;
	localparam int SWIDTH_W   = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [STYLE_W-1:0]  style_t;
	typedef logic [SWIDTH_W-1:0] swidth_t;

	// marker style codes, the unused codes behave as plus
	localparam style_t STYLE_CROSS   = 3'd0;
	localparam style_t STYLE_PLUS    = 3'd1;
	localparam style_t STYLE_SQUARE  = 3'd2;
	localparam style_t STYLE_CIRCLE  = 3'd3;
	localparam style_t STYLE_DIAMOND = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STYLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd1;

	localparam style_t  STYLE_RESET = STYLE_PLUS;
	localparam swidth_t WIDTH_RESET = 9'd16;

	// output levels
	localparam level_t LEVEL_FULL     = 8'd255;
	localparam level_t LEVEL_NONE     = 8'd0;
	localparam level_t ALPHA_EDGE     = 8'd128;
	localparam level_t ALPHA_EDGE_TIP = 8'd64;

	// circle distance carries 8 fraction bits: radicand scaled by 2^16
	localparam int SQRT_SHIFT = 16;
	// alpha ramp spans two units of doubled radius (one pixel): 512 in 8-bit fraction units
	localparam int RAMP_BITS  = 9;

endpackage

/* rtl/msp_pix_if.sv */
interface msp_pix_in_if import msp_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t row;
	coord_t column;

	modport source (output valid, output row, output column, input ready);
	modport sink (input valid, input row, input column, output ready);
endinterface

interface msp_pix_out_if import msp_pkg::*; ();
	logic   valid;
	logic   ready;
	level_t gray;
	level_t alpha;

	modport source (output valid, output gray, output alpha, input ready);
	modport sink (input valid, input gray, input alpha, output ready);
endinterface

/* rtl/marker_sprite_pixel_generator_unit.sv */
// marker sprite pixel generator
//
// pix_in carries one pixel coordinate (row, column) per transaction, pix_out
// returns its gray level and alpha, one result per input, in order. both are
// valid/ready channels; a transaction happens on a rising edge with valid and
// ready high. style and sprite_width are set through the write port (cfg_we,
// cfg_index, cfg_data) by the user while no pixel is in flight; not enforced.
//
// throughput: one pixel per clock while pix_out is not stalled. the path from
// the input transaction to pix_out.valid runs through ROOTB + 5 register
// stages set by the circle path: an input stage, a squaring stage, a sum
// stage, one integer square root stage per result bit (ROOTB of them) and two
// stages that turn the distance into alpha. every style runs the same depth.
//
// reset clears the valid bits and loads style plus, width 16. when the
// receiver stalls, the pipeline keeps filling its empty stages, so pix_in
// stays ready until every stage holds a pixel; nothing is dropped or repeated.
module marker_sprite_pixel_generator_unit import msp_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	msp_pix_in_if.sink            pix_in,
	msp_pix_out_if.source         pix_out
);

	// the width register is 9 bits, so the clamp only bites below 511
	localparam int WMAX  = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int WB    = $clog2(WMAX + 1);
	localparam int XW    = ((WB > COORD_W) ? WB : COORD_W) + 2;
	localparam int CMAX  = (2 ** COORD_W) - 1;
	localparam int MM    = ((WMAX - 1) > 2 * CMAX) ? (WMAX - 1) : (2 * CMAX);
	localparam int MB    = $clog2(MM + 1);
	localparam int SB    = 2 * MB + 1;
	localparam int ROOTB = (SB + SQRT_SHIFT + 1) / 2;
	localparam int XRW   = 2 * ROOTB;
	localparam int RW    = ROOTB + 3;
	localparam int NB    = (((WB + 8) > ROOTB) ? (WB + 8) : ROOTB) + 2;
	localparam int SQ0   = 3;
	localparam int SN    = SQ0 + ROOTB;
	localparam int NS    = SN + 2;

	// configuration registers
	style_t  style_q;
	swidth_t width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q <= STYLE_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STYLE: style_q <= cfg_data[STYLE_W-1:0];
				REG_WIDTH: width_q <= cfg_data[SWIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective width: zero acts as one, large values clamp
	logic [WB-1:0] w_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WB'(1);
		end else if (int'(width_q) > WMAX) begin
			w_eff = WB'(WMAX);
		end else begin
			w_eff = WB'(width_q);
		end
	end

	// valid bits, one per stage, and stage load enables
	// a stage loads when it is empty or its content moves on
	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || pix_out.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= pix_in.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign pix_in.ready = adv[0];

	// stage 1: offsets and line hits
	logic [XW-1:0] i_x, j_x, w_x, c_x, dxs, dys, a_x, b_x;
	logic [XW-1:0] dx_c, dy_c, mag_a_c, mag_b_c;
	logic          cross_hit, plus_hit;

	always_comb begin
		i_x       = XW'(pix_in.row);
		j_x       = XW'(pix_in.column);
		w_x       = XW'(w_eff);
		c_x       = (w_x - XW'(1)) >> 1;
		cross_hit = (i_x == j_x) || (i_x == (w_x - j_x));
		plus_hit  = (i_x == (w_x >> 1)) || (j_x == (w_x >> 1));
		dxs       = i_x - c_x;
		dys       = j_x - c_x;
		dx_c      = dxs[XW-1] ? (XW'(0) - dxs) : dxs;
		dy_c      = dys[XW-1] ? (XW'(0) - dys) : dys;
		// doubled offsets from the center
		a_x       = (i_x << 1) - (w_x - XW'(1));
		b_x       = (j_x << 1) - (w_x - XW'(1));
		mag_a_c   = a_x[XW-1] ? (XW'(0) - a_x) : a_x;
		mag_b_c   = b_x[XW-1] ? (XW'(0) - b_x) : b_x;
	end

	style_t        style_s1;
	logic          cross_s1, plus_s1;
	logic [XW-1:0] c_s1, dx_s1, dy_s1;
	logic [MB-1:0] maga_s1, magb_s1;
	logic [WB-1:0] w_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			style_s1 <= style_q;
			cross_s1 <= cross_hit;
			plus_s1  <= plus_hit;
			c_s1     <= c_x;
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			maga_s1  <= mag_a_c[MB-1:0];
			magb_s1  <= mag_b_c[MB-1:0];
			w_s1     <= w_eff;
		end
	end

	// stage 2: flat styles resolved, circle offsets squared
	logic [XW-1:0] cmd;
	logic          dia_in, dia_edge;
	level_t        ncg_c, nca_c;

	always_comb begin
		cmd      = c_s1 - dx_s1;
		dia_in   = $signed(cmd) > $signed(dy_s1);
		dia_edge = (cmd == dy_s1);
		case (style_s1)
			STYLE_CROSS: begin
				nca_c = cross_s1 ? LEVEL_FULL : LEVEL_NONE;
				ncg_c = nca_c;
			end
			STYLE_SQUARE: begin
				nca_c = LEVEL_FULL;
				ncg_c = LEVEL_FULL;
			end
			STYLE_CIRCLE: begin
				// alpha comes from the root path
				nca_c = LEVEL_NONE;
				ncg_c = LEVEL_FULL;
			end
			STYLE_DIAMOND: begin
				ncg_c = LEVEL_FULL;
				if (dia_in) begin
					nca_c = LEVEL_FULL;
				end else if (dia_edge) begin
					// the four tips are fainter than the rest of the rim
					nca_c = (dx_s1 == '0 || dy_s1 == '0) ? ALPHA_EDGE_TIP : ALPHA_EDGE;
				end else begin
					nca_c = LEVEL_NONE;
				end
			end
			default: begin
				nca_c = plus_s1 ? LEVEL_FULL : LEVEL_NONE;
				ncg_c = nca_c;
			end
		endcase
	end

	level_t          ncg_s2, nca_s2;
	logic            circ_s2;
	logic [2*MB-1:0] sqa_s2, sqb_s2;
	logic [WB-1:0]   w_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ncg_s2  <= ncg_c;
			nca_s2  <= nca_c;
			circ_s2 <= (style_s1 == STYLE_CIRCLE);
			sqa_s2  <= maga_s1 * maga_s1;
			sqb_s2  <= magb_s1 * magb_s1;
			w_s2    <= w_s1;
		end
	end

	// stage 3: sum of squares
	level_t        ncg_s3, nca_s3;
	logic          circ_s3;
	logic [SB-1:0] sum_s3;
	logic [WB-1:0] w_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			ncg_s3  <= ncg_s2;
			nca_s3  <= nca_s2;
			circ_s3 <= circ_s2;
			sum_s3  <= SB'(sqa_s2) + SB'(sqb_s2);
			w_s3    <= w_s2;
		end
	end

	// square root stages: one root bit per stage, two radicand bits consumed
	// arrays indexed by root stage, each entry lives in its own stage
	logic [RW-1:0]    rem_ss  [ROOTB];
	logic [ROOTB-1:0] root_ss [ROOTB];
	logic [XRW-1:0]   x_ss    [ROOTB];
	logic [WB-1:0]    w_ss    [ROOTB];
	logic             circ_ss [ROOTB];
	level_t           ncg_ss  [ROOTB];
	level_t           nca_ss  [ROOTB];

	logic [RW-1:0]    rem_in  [ROOTB];
	logic [ROOTB-1:0] root_in [ROOTB];
	logic [XRW-1:0]   x_in    [ROOTB];
	logic [WB-1:0]    w_in    [ROOTB];
	logic             circ_in [ROOTB];
	level_t           ncg_in  [ROOTB];
	level_t           nca_in  [ROOTB];

	for (genvar k = 0; k < ROOTB; k++) begin : g_root
		logic [RW-1:0] rr, trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
			assign x_in[k]    = XRW'({sum_s3, {SQRT_SHIFT{1'b0}}});
			assign w_in[k]    = w_s3;
			assign circ_in[k] = circ_s3;
			assign ncg_in[k]  = ncg_s3;
			assign nca_in[k]  = nca_s3;
		end else begin : g_next
			assign rem_in[k]  = rem_ss[k-1];
			assign root_in[k] = root_ss[k-1];
			assign x_in[k]    = x_ss[k-1];
			assign w_in[k]    = w_ss[k-1];
			assign circ_in[k] = circ_ss[k-1];
			assign ncg_in[k]  = ncg_ss[k-1];
			assign nca_in[k]  = nca_ss[k-1];
		end

		always_comb begin
			rr    = {rem_in[k][RW-3:0], x_in[k][XRW-1 -: 2]};
			trial = RW'({root_in[k], 2'b01});
			ge    = (rr >= trial);
		end

		always_ff @(posedge clk) begin
			if (adv[SQ0+k]) begin
				rem_ss[k]  <= ge ? (rr - trial) : rr;
				root_ss[k] <= {root_in[k][ROOTB-2:0], ge};
				x_ss[k]    <= x_in[k] << 2;
				w_ss[k]    <= w_in[k];
				circ_ss[k] <= circ_in[k];
				ncg_ss[k]  <= ncg_in[k];
				nca_ss[k]  <= nca_in[k];
			end
		end
	end

	// distance margin: n = w*256 - doubled distance, clamped to the ramp
	logic [NB-1:0] n_x;

	assign n_x = (NB'(w_ss[ROOTB-1]) << 8) - NB'(root_ss[ROOTB-1]);

	logic                 lo_sn, hi_sn, circ_sn;
	logic [RAMP_BITS-1:0] frac_sn;
	level_t               ncg_sn, nca_sn;

	always_ff @(posedge clk) begin
		if (adv[SN]) begin
			lo_sn   <= n_x[NB-1] || (n_x == '0);
			hi_sn   <= !n_x[NB-1] && (n_x >= NB'(2 ** RAMP_BITS));
			frac_sn <= n_x[RAMP_BITS-1:0];
			circ_sn <= circ_ss[ROOTB-1];
			ncg_sn  <= ncg_ss[ROOTB-1];
			nca_sn  <= nca_ss[ROOTB-1];
		end
	end

	// output stage: alpha = floor(255 * n / 512) inside the ramp
	logic [RAMP_BITS+LEVEL_W-1:0] ramp;
	level_t                       alpha_c;

	always_comb begin
		ramp = ((RAMP_BITS + LEVEL_W)'(frac_sn) << LEVEL_W) - (RAMP_BITS + LEVEL_W)'(frac_sn);
		if (!circ_sn) begin
			alpha_c = nca_sn;
		end else if (lo_sn) begin
			alpha_c = LEVEL_NONE;
		end else if (hi_sn) begin
			alpha_c = LEVEL_FULL;
		end else begin
			alpha_c = ramp[RAMP_BITS+LEVEL_W-1:RAMP_BITS];
		end
	end

	level_t gray_so, alpha_so;

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			gray_so  <= ncg_sn;
			alpha_so <= alpha_c;
		end
	end

	assign pix_out.valid = vld_s[NS-1];
	assign pix_out.gray  = gray_so;
	assign pix_out.alpha = alpha_so;

	// an empty output stage never blocks the input side
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NS-1] |-> pix_in.ready)
		else $error("input stalled with an empty output stage");

	// a full pipeline behind a stalled receiver takes nothing new
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_s) && !pix_out.ready) |-> !pix_in.ready)
		else $error("input accepted into a full stalled pipeline");

	// gray is always black or white
	a_gray_levels: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (pix_out.gray == LEVEL_NONE || pix_out.gray == LEVEL_FULL))
		else $error("gray level other than black or white");

endmodule

/* bench/marker_sprite_pixel_generator_unit_tb.sv */
`timescale 1ns / 100ps

module marker_sprite_pixel_generator_unit_tb;
	import msp_pkg::*;

	localparam int MAX_WIDTH  = 256;
	// hard stop, far beyond the slowest legal run
	localparam int TIMEOUT_NS = 1_000_000;
	// long receiver hold-off, well past the pipeline depth
	localparam int HOLD_CYCLES = 150;
	// cycles to watch for stray results after the last expected one
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	// style codes without a name of their own, all decode as plus
	localparam style_t STYLE_SPARE_LO  = 3'd5;
	localparam style_t STYLE_SPARE_MID = 3'd6;
	localparam style_t STYLE_SPARE_HI  = 3'd7;

	typedef struct packed {
		coord_t row;
		coord_t column;
	} pixel_coord_t;

	typedef struct packed {
		level_t gray;
		level_t alpha;
	} pixel_level_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	msp_pix_in_if  pix_in ();
	msp_pix_out_if pix_out ();

	marker_sprite_pixel_generator_unit #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix_in),
		.pix_out  (pix_out)
	);

	// coordinates waiting to be offered, and levels waiting to come back
	pixel_coord_t coord_queue[$];
	pixel_level_t expected_levels[$];

	// our own copy of the two registers, updated when a write lands
	style_t  cur_style;
	swidth_t cur_width;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;

	// receiver hold-off control
	bit hold_armed;
	bit hold_fired;
	int hold_left;

	pixel_coord_t next_coord;
	pixel_level_t want_level;

	// floor square root, one result bit per pass
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned rt;
		longint unsigned bitv;
		rt = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= rt + bitv) begin
				v = v - (rt + bitv);
				rt = (rt >> 1) + bitv;
			end else begin
				rt = rt >> 1;
			end
			bitv = bitv >> 2;
		end
		return rt;
	endfunction

	// gray level and alpha of one pixel under the given style and width
	function automatic pixel_level_t compute_level(style_t st, swidth_t wd, coord_t r, coord_t c);
		longint i;
		longint j;
		longint w;
		longint mid;
		longint ctr;
		longint dx;
		longint dy;
		longint a;
		longint b;
		longint radius2;
		longint n;
		longint unsigned radicand;
		pixel_level_t res;
		i = r;
		j = c;
		w = wd;
		// width zero acts as one, anything past the maximum is clipped
		if (w < 1)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		res.gray = LEVEL_NONE;
		res.alpha = LEVEL_NONE;
		case (st)
			STYLE_CROSS: begin
				if (i == j || i == w - j) begin
					res.gray = LEVEL_FULL;
					res.alpha = LEVEL_FULL;
				end
			end
			STYLE_SQUARE: begin
				res.gray = LEVEL_FULL;
				res.alpha = LEVEL_FULL;
			end
			STYLE_CIRCLE: begin
				// doubled offsets from the center keep everything integral
				a = 2 * i - (w - 1);
				b = 2 * j - (w - 1);
				radicand = a * a + b * b;
				radius2 = root_floor(radicand << SQRT_SHIFT);
				n = (w <<< (SQRT_SHIFT / 2)) - radius2;
				res.gray = LEVEL_FULL;
				if (n <= 0)
					res.alpha = LEVEL_NONE;
				else if (n >= (longint'(1) << RAMP_BITS))
					res.alpha = LEVEL_FULL;
				else
					res.alpha = level_t'((n * longint'(LEVEL_FULL)) >>> RAMP_BITS);
			end
			STYLE_DIAMOND: begin
				ctr = (w - 1) / 2;
				dx = i - ctr;
				dy = j - ctr;
				if (dx < 0)
					dx = -dx;
				if (dy < 0)
					dy = -dy;
				res.gray = LEVEL_FULL;
				if (ctr - dx > dy)
					res.alpha = LEVEL_FULL;
				else if (ctr - dx == dy)
					res.alpha = (dx == 0 || dy == 0) ? ALPHA_EDGE_TIP : ALPHA_EDGE;
				else
					res.alpha = LEVEL_NONE;
			end
			default: begin
				// plus and the spare codes
				mid = w / 2;
				if (i == mid || j == mid) begin
					res.gray = LEVEL_FULL;
					res.alpha = LEVEL_FULL;
				end
			end
		endcase
		return res;
	endfunction

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic offer_pixel(int r, int c);
		pixel_coord_t pc;
		pc.row = coord_t'(r);
		pc.column = coord_t'(c);
		coord_queue.push_back(pc);
	endtask

	// block until nothing is queued, offered or outstanding; checked on the
	// falling edge so the clocked processes have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (coord_queue.size() != 0 || pix_in.valid || expected_levels.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STYLE)
			cur_style = data[STYLE_W-1:0];
		else
			cur_width = data[SWIDTH_W-1:0];
	endtask

	// both registers, only once the block is idle
	task automatic configure(style_t s, swidth_t w);
		logic [CFG_DATA_W-1:0] style_word;
		wait_drained();
		// bits above the style field are don't-care, so fill them at random
		style_word = CFG_DATA_W'($urandom);
		style_word[STYLE_W-1:0] = s;
		write_reg(REG_STYLE, style_word);
		write_reg(REG_WIDTH, w);
		@(negedge clk);
	endtask

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	// sender: offer the head of the queue, keep it up until the transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
			pix_in.row <= '0;
			pix_in.column <= '0;
		end else begin
			if (pix_in.valid && pix_in.ready)
				expected_levels.push_back(compute_level(cur_style, cur_width,
					pix_in.row, pix_in.column));
			if (!pix_in.valid || pix_in.ready) begin
				if (coord_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_coord = coord_queue.pop_front();
					pix_in.valid <= 1'b1;
					pix_in.row <= next_coord.row;
					pix_in.column <= next_coord.column;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off counter, fires once when armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_fired <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_fired) begin
			hold_left <= HOLD_CYCLES;
			hold_fired <= 1'b1;
		end
	end

	// receiver: check each result transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_levels.size() == 0) begin
					note_failure($sformatf("unexpected result gray %0d alpha %0d",
						pix_out.gray, pix_out.alpha));
				end else begin
					want_level = expected_levels.pop_front();
					if (want_level.gray !== pix_out.gray || want_level.alpha !== pix_out.alpha)
						note_failure($sformatf(
							"level mismatch: expected gray %0d alpha %0d, got gray %0d alpha %0d",
							want_level.gray, want_level.alpha, pix_out.gray, pix_out.alpha));
				end
			end
			pix_out.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		int mode;
		int n_items;
		int eff;
		int lim;
		int r;
		int c;
		swidth_t wsel;

		// every driven input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.row = '0;
		pix_in.column = '0;
		pix_out.ready = 1'b0;
		cur_style = STYLE_RESET;
		cur_width = WIDTH_RESET;
		send_idle_pct = 22;
		recv_idle_pct = 62;
		mismatch_count = 0;
		hold_armed = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: plus at width 16, middle row and column lit
		offer_pixel(8, 0);
		offer_pixel(0, 8);
		offer_pixel(0, 0);
		offer_pixel(255, 255);

		// cross: main diagonal and the anti-diagonal row == w - column
		configure(STYLE_CROSS, 9'd16);
		offer_pixel(3, 3);
		offer_pixel(5, 11);
		offer_pixel(0, 16);
		offer_pixel(4, 5);

		configure(STYLE_SQUARE, 9'd1);
		offer_pixel(200, 100);

		// circle: center, corner, and a point on the anti-aliased rim
		configure(STYLE_CIRCLE, 9'd16);
		offer_pixel(7, 7);
		offer_pixel(0, 0);
		offer_pixel(8, 15);

		// diamond: edge tip, inside, edge, outside
		configure(STYLE_DIAMOND, 9'd16);
		offer_pixel(7, 0);
		offer_pixel(4, 4);
		offer_pixel(3, 4);
		offer_pixel(3, 3);

		// width zero acts as one
		configure(STYLE_PLUS, 9'd0);
		offer_pixel(0, 0);
		offer_pixel(1, 1);

		// spare style codes with widths at and beyond the maximum
		configure(STYLE_SPARE_LO, 9'd300);
		offer_pixel(128, 3);
		configure(STYLE_SPARE_MID, 9'd256);
		offer_pixel(0, 128);
		configure(STYLE_SPARE_HI, 9'd511);
		offer_pixel(255, 0);
		offer_pixel(127, 129);

		// random part: three idling modes, eight styles each
		for (int p = 0; p < 24; p++) begin
			mode = p / 8;
			case ($urandom_range(0, 9))
				0: wsel = 9'd0;
				1: wsel = 9'd1;
				2: wsel = 9'd256;
				3: wsel = swidth_t'($urandom_range(257, 511));
				4: wsel = 9'd2;
				5: wsel = swidth_t'($urandom_range(41, 255));
				default: wsel = swidth_t'($urandom_range(3, 40));
			endcase
			configure(style_t'(p % 8), wsel);
			if (mode == 0) begin
				send_idle_pct = 22;
				recv_idle_pct = 62;
			end else if (mode == 1) begin
				send_idle_pct = 62;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// first phase without idling: long receiver hold-off, sender keeps
			// pushing so the pipeline fills and pix_in backs up
			n_items = 44;
			if (p == 16) begin
				hold_armed = 1'b1;
				n_items = 120;
			end
			eff = (wsel == 0) ? 1 : ((wsel > MAX_WIDTH) ? MAX_WIDTH : int'(wsel));
			lim = eff - 1;
			for (int k = 0; k < n_items; k++) begin
				// mostly pixels inside the sprite, some anywhere in the field
				if ($urandom_range(0, 9) < 7) begin
					r = $urandom_range(0, lim);
					c = $urandom_range(0, lim);
				end else begin
					r = $urandom_range(0, 255);
					c = $urandom_range(0, 255);
				end
				offer_pixel(r, c);
			end
		end

		wait_drained();
		// catch stray results after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_levels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
